// ===== sv/osse_pkg.sv =====
`default_nettype none

package osse_pkg;

  // Default table depth
  localparam int CAPACITY_DEF = 256;

  // Operation codes
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_EXISTS = 3'd2,
    OP_NEXT   = 3'd3,
    OP_PREV   = 3'd4
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } state_t;

  // Request beat
  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] key;
  } req_t;

  // Response beat
  typedef struct packed {
    logic               found;
    logic signed [31:0] value;
    logic               status;
  } rsp_t;

  // Decisions from the compare unit for one table entry
  typedef struct packed {
    logic hit;   // valid entry equal to key
    logic free;  // entry not in use
    logic best;  // entry is a closer neighbor than the current best
  } scan_upd_t;

endpackage

`default_nettype wire

// ===== sv/osse_scan_unit.sv =====
`default_nettype none

// Compare unit shared by every step of the table sweep: judges one entry
// against the search key and the running best neighbor.
module osse_scan_unit (
  input  wire logic               ent_valid,
  input  wire logic signed [31:0] ent_value,
  input  wire logic [2:0]         operation,
  input  wire logic signed [31:0] key,
  input  wire logic               best_have,
  input  wire logic signed [31:0] best,
  output osse_pkg::scan_upd_t     upd
);

  logic above_key;
  logic below_key;
  logic below_best;
  logic above_best;

  assign above_key  = ent_value > key;
  assign below_key  = ent_value < key;
  assign below_best = ent_value < best;
  assign above_best = ent_value > best;

  // Per-entry decisions
  always_comb begin
    upd.hit  = ent_valid && (ent_value == key);
    upd.free = !ent_valid;
    case (operation)
      osse_pkg::OP_NEXT: upd.best = ent_valid && above_key && (!best_have || below_best);
      osse_pkg::OP_PREV: upd.best = ent_valid && below_key && (!best_have || above_best);
      default:           upd.best = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ordered_set_successor_engine_top.sv =====
`default_nettype none

// Ordered set of distinct signed 32-bit keys in a table of CAPACITY slots.
// Request channel (req_valid / req_stall / req): one beat carries an
// operation (insert, delete, exists, next greater, previous smaller) and a
// key. Response channel (rsp_valid / rsp_stall / rsp): one beat per request
// with found, value and status (status set when an insert of an absent key meets a full set).
// Each request sweeps the whole table through one read port of the slot
// memory, one slot per cycle, judging each slot in one compare unit; the
// memory's read is registered, and a commit state writes back. req_stall
// is high while a request is in work.
// After rst the block runs a clearing pass that marks every slot free;
// req_stall stays high during it.
// The response sits in an output register: a new request is accepted while
// it waits, and if rsp_stall still holds it when the next result is ready,
// the commit waits until the waiting beat is taken.
module ordered_set_successor_engine_top #(
  parameter int CAPACITY = osse_pkg::CAPACITY_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire osse_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output osse_pkg::rsp_t      rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  osse_pkg::state_t state;
  osse_pkg::state_t state_next;

  // Slot memory: valid bit over key
  logic [32:0] mem [CAPACITY];
  logic [32:0] rd_data;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [32:0] mem_wd;

  logic [AW-1:0] cnt;
  logic          cnt_last;
  logic          rd_pend;
  logic [AW-1:0] rd_slot;

  osse_pkg::req_t req_q;
  logic [CW-1:0]  count;
  logic           full;

  // Sweep accumulators
  logic               hit;
  logic [AW-1:0]      hit_slot;
  logic               free_have;
  logic [AW-1:0]      free_slot;
  logic               best_have;
  logic signed [31:0] best;

  osse_pkg::scan_upd_t upd;
  osse_pkg::rsp_t      result;
  logic                out_free;
  logic                do_commit;
  logic                do_insert;
  logic                do_delete;
  logic                req_take;

  assign cnt_last  = (cnt == LAST_SLOT);
  assign full      = (count == FULL_COUNT);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign do_commit = (state == osse_pkg::ST_COMMIT) && out_free;
  assign do_insert = (req_q.operation == osse_pkg::OP_INSERT) && !hit && !full;
  assign do_delete = (req_q.operation == osse_pkg::OP_DELETE) && hit;
  assign req_take  = req_valid && !req_stall;

  // Compare unit
  osse_scan_unit u_scan (
    .ent_valid (rd_data[32]),
    .ent_value (rd_data[31:0]),
    .operation (req_q.operation),
    .key       (req_q.key),
    .best_have (best_have),
    .best      (best),
    .upd       (upd)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      osse_pkg::ST_CLEAR:  if (cnt_last) state_next = osse_pkg::ST_IDLE;
      osse_pkg::ST_IDLE:   if (req_valid) state_next = osse_pkg::ST_SCAN;
      osse_pkg::ST_SCAN:   if (cnt_last) state_next = osse_pkg::ST_LAST;
      osse_pkg::ST_LAST:   state_next = osse_pkg::ST_COMMIT;
      osse_pkg::ST_COMMIT: if (out_free) state_next = osse_pkg::ST_IDLE;
      default:             state_next = osse_pkg::ST_CLEAR;
    endcase
  end

  // Sequencer outputs: handshake and memory write port
  always_comb begin
    req_stall = 1'b1;
    mem_we    = 1'b0;
    mem_wa    = cnt;
    mem_wd    = {1'b0, req_q.key};
    case (state)
      osse_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      osse_pkg::ST_IDLE: begin
        req_stall = 1'b0;
      end
      osse_pkg::ST_COMMIT: begin
        if (do_insert) begin
          mem_we = out_free;
          mem_wa = free_slot;
          mem_wd = {1'b1, req_q.key};
        end else if (do_delete) begin
          mem_we = out_free;
          mem_wa = hit_slot;
        end
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // Result of the finished sweep
  always_comb begin
    result = '0;
    case (req_q.operation)
      osse_pkg::OP_INSERT: begin
        result.found  = hit;
        result.status = !hit && full;
      end
      osse_pkg::OP_DELETE,
      osse_pkg::OP_EXISTS: result.found = hit;
      osse_pkg::OP_NEXT,
      osse_pkg::OP_PREV: begin
        result.found = best_have;
        result.value = best_have ? best : 32'sd0;
      end
      default: result = '0;
    endcase
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[cnt];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= osse_pkg::ST_CLEAR;
      cnt       <= '0;
      rd_pend   <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == osse_pkg::ST_SCAN);
      if (state == osse_pkg::ST_CLEAR || state == osse_pkg::ST_SCAN) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end
      if (do_commit) begin
        rsp_valid <= 1'b1;
        if (do_insert) begin
          count <= count + 1'b1;
        end else if (do_delete) begin
          count <= count - 1'b1;
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request latch, sweep accumulators and response payload
  always_ff @(posedge clk) begin
    rd_slot <= cnt;
    if (req_take) begin
      req_q     <= req;
      hit       <= 1'b0;
      free_have <= 1'b0;
      best_have <= 1'b0;
      best      <= 32'sd0;
      hit_slot  <= '0;
      free_slot <= '0;
    end else if (rd_pend) begin
      if (upd.hit) begin
        hit      <= 1'b1;
        hit_slot <= rd_slot;
      end
      if (upd.free && !free_have) begin
        free_have <= 1'b1;
        free_slot <= rd_slot;
      end
      if (upd.best) begin
        best_have <= 1'b1;
        best      <= rd_data[31:0];
      end
    end
    if (do_commit) begin
      rsp <= result;
    end
  end

  // Checks
  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == osse_pkg::ST_COMMIT))
    else $error("response raised outside commit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above capacity");

  a_take_starts_scan: assert property (@(posedge clk) disable iff (rst)
    req_take |=> state == osse_pkg::ST_SCAN)
    else $error("accepted request did not start a sweep");

  a_drop_not_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.status && rsp.found))
    else $error("dropped insert reported as found");

endmodule

`default_nettype wire
